// ===== hdl/bss_pkg.sv =====
// bss_pkg: shared types and constants of the binomial smoothing stencil
// payload structs for the sample and result channels, pipeline flag struct
// no dependencies
`timescale 1ns / 1ps

package bss_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int SIZE_Z_LIMIT = 64;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS = 7;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIMENSIONS = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_X = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_Y = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_Z = 8'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] cur_x;
		logic signed [SAMPLE_BITS-1:0] cur_y;
		logic signed [SAMPLE_BITS-1:0] cur_z;
		logic end_of_grid;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smooth_x;
		logic signed [SAMPLE_BITS-1:0] smooth_y;
		logic signed [SAMPLE_BITS-1:0] smooth_z;
		logic last_cell;
	} result_t;

	typedef struct packed {
		logic emit;
		logic last;
	} bss_flags_t;

endpackage

// ===== hdl/binomial_smoothing_stencil_top.sv =====
// binomial_smoothing_stencil_top: separable 3-point binomial smoothing pipeline
// depends on bss_pkg, bss_seq, bss_ram
`timescale 1ns / 1ps

// Takes one padded cell per cycle and moves each smoothed interior cell through
// s1, s2 and res_q after the input completing its neighborhood. The filter runs
// separably: a plane ram (one entry per padded x,y) holds each column's two
// previous samples for the z pass, a row ram (one entry per padded x) holds
// two previous z-smoothed rows for the y pass, and two registers per component
// finish the x pass. Each ram entry is read and written back once per item, so
// the rate is one cell per cycle; a stalled result freezes the whole pipeline.
// Config writes to indexes 0-3 restart the grid position; rams need no clearing.
module binomial_smoothing_stencil_top
	import bss_pkg::*;
#(
	parameter int MAX_SIZE_X = 64,
	parameter int MAX_SIZE_Y = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  sample_t                   sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int W = SAMPLE_BITS;
	localparam int VZ = W + 2;
	localparam int VY = W + 4;
	localparam int SW = W + 6;
	localparam int PAD_X = MAX_SIZE_X + 2;
	localparam int PAD_Y = MAX_SIZE_Y + 2;
	localparam int XW = $clog2(PAD_X);
	localparam int AW = $clog2(PAD_X * PAD_Y);

	logic            adv, accept;
	logic [1:0]      d;
	logic [XW-1:0]   pos_x;
	logic [AW-1:0]   addr;
	bss_flags_t      flags;

	logic            v_s1, v_s2;
	bss_flags_t      fl_s1, fl_s2;
	logic [XW-1:0]   x_s1, x_s2;
	logic [AW-1:0]   addr_s1;
	logic signed [W-1:0]  cur_s1 [3];
	logic signed [VZ-1:0] vz_s2 [3];
	logic signed [VY-1:0] xw1_q [3];
	logic signed [VY-1:0] xw2_q [3];

	logic signed [W-1:0]  cur_in [3];
	logic signed [VZ-1:0] vz [3];
	logic signed [VY-1:0] vy [3];
	logic signed [W-1:0]  smooth [3];

	logic [6*W-1:0]  prd, pwd;
	logic [6*VZ-1:0] rrd, rwd;

	logic    out_valid_q;
	result_t res_q;

	assign adv = !out_valid_q || !result_stall;
	assign sample_stall = !adv;
	assign accept = sample_valid && adv;
	assign cfg_ready = 1'b1;
	assign result_valid = out_valid_q;
	assign result = res_q;

	assign cur_in[0] = sample.cur_x;
	assign cur_in[1] = sample.cur_y;
	assign cur_in[2] = sample.cur_z;

	bss_seq #(
		.MAX_SIZE_X(MAX_SIZE_X),
		.MAX_SIZE_Y(MAX_SIZE_Y)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (accept),
		.end_of_grid(sample.end_of_grid),
		.dims       (d),
		.pos_x      (pos_x),
		.addr       (addr),
		.flags      (flags)
	);

	// column history: {sample at z-2, sample at z-1} per component
	bss_ram #(
		.WIDTH(6 * W),
		.DEPTH(PAD_X * PAD_Y)
	) u_plane_ram (
		.clk  (clk),
		.we   (adv && v_s1),
		.waddr(addr_s1),
		.wdata(pwd),
		.re   (adv),
		.raddr(addr),
		.rdata(prd)
	);

	// row history: {z-smoothed row y-2, row y-1} per component
	bss_ram #(
		.WIDTH(6 * VZ),
		.DEPTH(PAD_X)
	) u_row_ram (
		.clk  (clk),
		.we   (adv && v_s2),
		.waddr(x_s2),
		.wdata(rwd),
		.re   (adv),
		.raddr(x_s1),
		.rdata(rrd)
	);

	for (genvar c = 0; c < 3; c++) begin : g_comp
		logic signed [W-1:0]  h0, h1;
		logic signed [VZ-1:0] r0, r1;
		logic signed [SW-1:0] sum;

		assign h0 = $signed(prd[c*2*W +: W]);
		assign h1 = $signed(prd[c*2*W+W +: W]);
		assign pwd[c*2*W +: 2*W] = {h0, cur_s1[c]};
		assign vz[c] = (d == 2'd3) ? (VZ'(h1) + (VZ'(h0) <<< 1) + VZ'(cur_s1[c]))
			: VZ'(cur_s1[c]);

		assign r0 = $signed(rrd[c*2*VZ +: VZ]);
		assign r1 = $signed(rrd[c*2*VZ+VZ +: VZ]);
		assign rwd[c*2*VZ +: 2*VZ] = {r0, vz_s2[c]};
		assign vy[c] = (d >= 2'd2) ? (VY'(r1) + (VY'(r0) <<< 1) + VY'(vz_s2[c]))
			: VY'(vz_s2[c]);

		assign sum = SW'(xw2_q[c]) + (SW'(xw1_q[c]) <<< 1) + SW'(vy[c]);

		// round half up, then shift by two bits per active axis
		always_comb begin
			unique case (d)
				2'd3: smooth[c] = W'((sum + SW'(32)) >>> 6);
				2'd2: smooth[c] = W'((sum + SW'(8)) >>> 4);
				default: smooth[c] = W'((sum + SW'(2)) >>> 2);
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cur_s1[c] <= cur_in[c];
				vz_s2[c] <= vz[c];
				if (v_s2) begin
					xw2_q[c] <= xw1_q[c];
					xw1_q[c] <= vy[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s1 <= flags;
			x_s1 <= pos_x;
			addr_s1 <= addr;
			fl_s2 <= fl_s1;
			x_s2 <= x_s1;
			res_q.smooth_x <= smooth[0];
			res_q.smooth_y <= smooth[1];
			res_q.smooth_z <= smooth[2];
			res_q.last_cell <= fl_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			out_valid_q <= v_s2 && fl_s2.emit;
		end
	end

endmodule

// ===== hdl/bss_ram.sv =====
// bss_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps

module bss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/bss_seq.sv =====
// bss_seq: configuration registers and padded grid position sequencer
// depends on bss_pkg
`timescale 1ns / 1ps

module bss_seq
	import bss_pkg::*;
#(
	parameter int MAX_SIZE_X = 64,
	parameter int MAX_SIZE_Y = 64
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0]                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]                      cfg_data,
	input  logic                                          step,
	input  logic                                          end_of_grid,
	output logic [1:0]                                    dims,
	output logic [$clog2(MAX_SIZE_X+2)-1:0]               pos_x,
	output logic [$clog2((MAX_SIZE_X+2)*(MAX_SIZE_Y+2))-1:0] addr,
	output bss_flags_t                                    flags
);

	localparam int PAD_X = MAX_SIZE_X + 2;
	localparam int PAD_Y = MAX_SIZE_Y + 2;
	localparam int XW = $clog2(PAD_X);
	localparam int YW = $clog2(PAD_Y);
	localparam int AW = $clog2(PAD_X * PAD_Y);

	logic [1:0]               dims_q;
	logic [CFG_DATA_BITS-1:0] size_x_q, size_y_q, size_z_q;
	logic [XW-1:0]            pos_x_q, x_last;
	logic [YW-1:0]            pos_y_q, y_last, y_clamp;
	logic [6:0]               pos_z_q, z_last, z_clamp;
	logic [1:0]               d;
	logic                     at_end;

	assign d = (dims_q == 2'd0) ? 2'd1 : dims_q;

	// last padded index per active axis is clamped size plus one, zero when inactive
	always_comb begin
		if (size_x_q == '0) begin
			x_last = XW'(2);
		end else if (32'(size_x_q) > MAX_SIZE_X) begin
			x_last = XW'(MAX_SIZE_X + 1);
		end else begin
			x_last = XW'(size_x_q) + XW'(1);
		end
		if (size_y_q == '0) begin
			y_clamp = YW'(2);
		end else if (32'(size_y_q) > MAX_SIZE_Y) begin
			y_clamp = YW'(MAX_SIZE_Y + 1);
		end else begin
			y_clamp = YW'(size_y_q) + YW'(1);
		end
		if (size_z_q == '0) begin
			z_clamp = 7'd2;
		end else if (32'(size_z_q) > SIZE_Z_LIMIT) begin
			z_clamp = 7'(SIZE_Z_LIMIT + 1);
		end else begin
			z_clamp = size_z_q + 7'd1;
		end
		y_last = (d >= 2'd2) ? y_clamp : '0;
		z_last = (d == 2'd3) ? z_clamp : '0;
	end

	assign at_end = (pos_x_q == x_last) && (pos_y_q == y_last) && (pos_z_q == z_last);

	assign flags.emit = (pos_x_q >= XW'(2)) && ((d < 2'd2) || (pos_y_q >= YW'(2)))
		&& ((d < 2'd3) || (pos_z_q >= 7'd2));
	assign flags.last = at_end;
	assign dims = d;
	assign pos_x = pos_x_q;
	assign addr = AW'(pos_y_q) * AW'(PAD_X) + AW'(pos_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 2'd3;
			size_x_q <= 7'd64;
			size_y_q <= 7'd64;
			size_z_q <= 7'd64;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIMENSIONS: dims_q <= cfg_data[1:0];
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index <= REG_SIZE_Z) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
			end
		end else if (step) begin
			if (end_of_grid || at_end) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
			end else if (pos_x_q == x_last) begin
				pos_x_q <= '0;
				if (pos_y_q == y_last) begin
					pos_y_q <= '0;
					pos_z_q <= pos_z_q + 7'd1;
				end else begin
					pos_y_q <= pos_y_q + YW'(1);
				end
			end else begin
				pos_x_q <= pos_x_q + XW'(1);
			end
		end
	end

endmodule
